@@ hw/rtl/bba_pkg.sv @@
// Shared types, constants and helper functions of the buddy block allocator.
package bba_pkg;

    localparam int TOTAL_LOG = 16;
    localparam int MIN_LOG   = 4;
    localparam int NLEV      = TOTAL_LOG - MIN_LOG + 1;
    localparam int GRAN_W    = TOTAL_LOG - MIN_LOG;
    localparam int NGRAN     = 1 << GRAN_W;
    localparam int LINK_W    = GRAN_W + 1;
    localparam int LV_W      = $clog2(NLEV);
    localparam int TAG_W     = LV_W + 1;
    localparam int CNT_W     = TOTAL_LOG + 1;
    localparam int REQ_W     = 17;
    localparam int ADDR_W    = 32;
    localparam int HDR_W     = 4;
    localparam int NEED_W    = REQ_W + 1;
    localparam int LG_W      = $clog2(NEED_W + 1);

    typedef logic [LINK_W-1:0] link_t;
    typedef logic [GRAN_W-1:0] gran_t;
    typedef logic [LV_W-1:0]   lvl_t;
    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam link_t NIL    = link_t'(NGRAN);
    localparam cnt_t  REGION = cnt_t'(1) << TOTAL_LOG;
    localparam lvl_t  LV_MIN = lvl_t'(NLEV - 1);

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_BIG   = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_HEADER = 1'b1;

    typedef struct packed {
        logic  link_we;
        gran_t link_waddr;
        link_t link_wdata;
        gran_t link_raddr;
        logic  tag_we;
        gran_t tag_waddr;
        tag_t  tag_wdata;
        gran_t tag_raddr;
    } ram_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted;
        cnt_t              free_bytes;
    } result_t;

    function automatic gran_t span_of(input lvl_t lv);
        link_t s;
        s = link_t'(1) << (NLEV - 1 - int'(lv));
        return s[GRAN_W-1:0];
    endfunction

    function automatic cnt_t bytes_of(input lvl_t lv);
        return cnt_t'(1) << (TOTAL_LOG - int'(lv));
    endfunction

endpackage

@@ hw/rtl/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: ports, configuration, memories and result register.
// An allocate searches the levels above its own and splits a larger block down when needed; a
// refused word goes straight to the response, after a search for an exhausted allocate.
// A free writes its block back and then merges it level by level, walking each free list.
// Throughput is one word at a time; the next word is taken as soon as the engine is idle.
// After reset a clearing pass writes all 4096 entries of the tag and link memories before the
// first word is accepted; configuration writes are taken at any time.
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [31:0]       cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,  // request_bytes[16:0], free_address[48:17], zero pad
    input  logic              s_tuser,  // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,  // granted_address[31:0], free_bytes[48:32], zero pad
    output logic [1:0]        m_tuser   // status
);
    logic [ADDR_W-1:0] base_reg;
    logic [HDR_W-1:0]  hdr_reg;
    logic              m_valid_reg;
    result_t           out_reg;
    logic              idle;
    logic              res_valid;
    logic              res_ready;
    result_t           result;
    ram_req_t          ram;
    link_t             link_rdata;
    tag_t              tag_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            hdr_reg  <= HDR_W'(8);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BASE:   base_reg <= cfg_wr_data;
                CFG_HEADER: hdr_reg  <= cfg_wr_data[HDR_W-1:0];
                default:    base_reg <= base_reg;
            endcase
        end
    end

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            out_reg <= result;
        end
    end

    assign s_tready = idle;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.free_bytes, out_reg.granted};

    bba_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_tvalid),
        .cmd        (s_tuser),
        .req_bytes  (s_tdata[16:0]),
        .free_addr  (s_tdata[48:17]),
        .base_addr  (base_reg),
        .hdr_bytes  (hdr_reg),
        .link_rdata (link_rdata),
        .tag_rdata  (tag_rdata),
        .res_ready  (res_ready),
        .idle       (idle),
        .res_valid  (res_valid),
        .result     (result),
        .ram        (ram)
    );

    bba_ram #(.WIDTH(LINK_W), .DEPTH(NGRAN)) u_link_ram (
        .aclk  (aclk),
        .we    (ram.link_we),
        .waddr (ram.link_waddr),
        .wdata (ram.link_wdata),
        .raddr (ram.link_raddr),
        .rdata (link_rdata)
    );

    bba_ram #(.WIDTH(TAG_W), .DEPTH(NGRAN)) u_tag_ram (
        .aclk  (aclk),
        .we    (ram.tag_we),
        .waddr (ram.tag_waddr),
        .wdata (ram.tag_wdata),
        .raddr (ram.tag_raddr),
        .rdata (tag_rdata)
    );
endmodule

@@ hw/rtl/bba_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/bba_engine.sv @@
// Sequencer that walks the free lists and levels held in the link and tag memories.
module bba_engine
    import bba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              cmd,
    input  logic [REQ_W-1:0]  req_bytes,
    input  logic [ADDR_W-1:0] free_addr,
    input  logic [ADDR_W-1:0] base_addr,
    input  logic [HDR_W-1:0]  hdr_bytes,
    input  link_t             link_rdata,
    input  tag_t              tag_rdata,
    input  logic              res_ready,
    output logic              idle,
    output logic              res_valid,
    output result_t           result,
    output ram_req_t          ram
);
    typedef enum logic [15:0] {
        ST_CLEAR   = 16'h0001,
        ST_IDLE    = 16'h0002,
        ST_DECODE  = 16'h0004,
        ST_SEARCH  = 16'h0008,
        ST_SPL_RD  = 16'h0010,
        ST_SPL_A   = 16'h0020,
        ST_SPL_B   = 16'h0040,
        ST_POP_RD  = 16'h0080,
        ST_POP_WR  = 16'h0100,
        ST_FREE_RD = 16'h0200,
        ST_FREE_WR = 16'h0400,
        ST_MRG     = 16'h0800,
        ST_MRG_CHK = 16'h1000,
        ST_MRG_CUT = 16'h2000,
        ST_MRG_PSH = 16'h4000,
        ST_RESP    = 16'h8000
    } state_t;

    state_t            state_reg;
    link_t             head_reg [NLEV];
    cnt_t              free_total_reg;
    gran_t             clr_reg;
    logic              cmd_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [ADDR_W-1:0] addr_reg;
    lvl_t              lv_reg;
    lvl_t              i_reg;
    gran_t             g_reg;
    gran_t             big_reg;
    gran_t             cur_reg;
    gran_t             prev_reg;
    gran_t             buddy_reg;
    link_t             cur_next_reg;
    logic [1:0]        status_reg;
    logic [ADDR_W-1:0] granted_reg;

    logic [NEED_W-1:0] need;
    logic [NEED_W-1:0] need_m1;
    logic [LG_W-1:0]   lg;
    logic              too_big;
    lvl_t              lv_req;
    logic [ADDR_W-1:0] off;
    logic              free_ok;
    gran_t             upper;
    lvl_t              tag_lv;
    gran_t             nx;
    gran_t             low_half;

    always_comb begin
        need    = NEED_W'(req_reg) + NEED_W'(hdr_bytes);
        need_m1 = need - NEED_W'(1);
        lg      = '0;
        if (need > NEED_W'(1)) begin
            for (int b = 0; b < NEED_W; b++) begin
                if (need_m1[b]) begin
                    lg = LG_W'(b + 1);
                end
            end
        end
        too_big = lg > LG_W'(TOTAL_LOG);
        if (lg < LG_W'(MIN_LOG)) begin
            lv_req = LV_MIN;
        end else begin
            lv_req = lvl_t'(LG_W'(TOTAL_LOG) - lg);
        end
    end

    assign off      = addr_reg - base_addr - ADDR_W'(hdr_bytes);
    assign free_ok  = (addr_reg != '0) && (off[ADDR_W-1:TOTAL_LOG] == '0)
                      && (off[MIN_LOG-1:0] == '0);
    assign upper    = big_reg + span_of(i_reg + lvl_t'(1));
    assign tag_lv   = (tag_rdata[LV_W-1:0] > LV_MIN) ? LV_MIN : tag_rdata[LV_W-1:0];
    assign nx       = link_rdata[GRAN_W-1:0];
    assign low_half = (cur_reg < buddy_reg) ? cur_reg : buddy_reg;

    always_comb begin
        ram = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram.link_we    = 1'b1;
                ram.link_waddr = clr_reg;
                ram.link_wdata = NIL;
                ram.tag_we     = 1'b1;
                ram.tag_waddr  = clr_reg;
            end
            ST_SPL_RD: ram.link_raddr = head_reg[i_reg][GRAN_W-1:0];
            ST_SPL_A: begin
                ram.link_we    = 1'b1;
                ram.link_waddr = upper;
                ram.link_wdata = head_reg[i_reg + lvl_t'(1)];
            end
            ST_SPL_B: begin
                ram.link_we    = 1'b1;
                ram.link_waddr = big_reg;
                ram.link_wdata = {1'b0, upper};
            end
            ST_POP_RD: ram.link_raddr = head_reg[lv_reg][GRAN_W-1:0];
            ST_POP_WR: begin
                ram.tag_we    = 1'b1;
                ram.tag_waddr = g_reg;
                ram.tag_wdata = {1'b1, lv_reg};
            end
            ST_FREE_RD: ram.tag_raddr = g_reg;
            ST_FREE_WR: begin
                if (tag_rdata[TAG_W-1]) begin
                    ram.tag_we     = 1'b1;
                    ram.tag_waddr  = g_reg;
                    ram.link_we    = 1'b1;
                    ram.link_waddr = g_reg;
                    ram.link_wdata = head_reg[tag_lv];
                end
            end
            ST_MRG: ram.link_raddr = head_reg[lv_reg][GRAN_W-1:0];
            ST_MRG_CHK: ram.link_raddr = nx;
            ST_MRG_CUT: begin
                ram.link_we    = 1'b1;
                ram.link_waddr = prev_reg;
                ram.link_wdata = link_rdata;
            end
            ST_MRG_PSH: begin
                ram.link_we    = 1'b1;
                ram.link_waddr = low_half;
                ram.link_wdata = head_reg[lv_reg - lvl_t'(1)];
            end
            default: ram = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            free_total_reg <= REGION;
            for (int k = 0; k < NLEV; k++) begin
                head_reg[k] <= (k == 0) ? link_t'(0) : NIL;
            end
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + gran_t'(1);
                    if (clr_reg == gran_t'(NGRAN - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        cmd_reg   <= cmd;
                        req_reg   <= req_bytes;
                        addr_reg  <= free_addr;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    status_reg  <= STATUS_OK;
                    granted_reg <= '0;
                    g_reg       <= off[TOTAL_LOG-1:MIN_LOG];
                    lv_reg      <= lv_req;
                    i_reg       <= lv_req - lvl_t'(1);
                    if (cmd_reg == CMD_FREE) begin
                        state_reg <= free_ok ? ST_FREE_RD : ST_RESP;
                    end else if (too_big) begin
                        status_reg <= STATUS_TOO_BIG;
                        state_reg  <= ST_RESP;
                    end else if (!head_reg[lv_req][GRAN_W]) begin
                        state_reg <= ST_POP_RD;
                    end else if (lv_req == '0) begin
                        status_reg <= STATUS_EXHAUSTED;
                        state_reg  <= ST_RESP;
                    end else begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (!head_reg[i_reg][GRAN_W]) begin
                        state_reg <= ST_SPL_RD;
                    end else if (i_reg == '0) begin
                        status_reg <= STATUS_EXHAUSTED;
                        state_reg  <= ST_RESP;
                    end else begin
                        i_reg <= i_reg - lvl_t'(1);
                    end
                end
                ST_SPL_RD: begin
                    big_reg   <= head_reg[i_reg][GRAN_W-1:0];
                    state_reg <= ST_SPL_A;
                end
                ST_SPL_A: begin
                    head_reg[i_reg] <= link_rdata;
                    state_reg       <= ST_SPL_B;
                end
                ST_SPL_B: begin
                    head_reg[i_reg + lvl_t'(1)] <= {1'b0, big_reg};
                    i_reg <= i_reg + lvl_t'(1);
                    state_reg <= (i_reg + lvl_t'(1) == lv_reg) ? ST_POP_RD : ST_SPL_RD;
                end
                ST_POP_RD: begin
                    g_reg     <= head_reg[lv_reg][GRAN_W-1:0];
                    state_reg <= ST_POP_WR;
                end
                ST_POP_WR: begin
                    head_reg[lv_reg] <= link_rdata;
                    free_total_reg   <= free_total_reg - bytes_of(lv_reg);
                    granted_reg      <= base_addr + (ADDR_W'(g_reg) << MIN_LOG)
                                        + ADDR_W'(hdr_bytes);
                    state_reg        <= ST_RESP;
                end
                ST_FREE_RD: state_reg <= ST_FREE_WR;
                ST_FREE_WR: begin
                    if (tag_rdata[TAG_W-1]) begin
                        head_reg[tag_lv] <= {1'b0, g_reg};
                        free_total_reg   <= free_total_reg + bytes_of(tag_lv);
                        lv_reg           <= tag_lv;
                        state_reg        <= ST_MRG;
                    end else begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_MRG: begin
                    cur_reg   <= head_reg[lv_reg][GRAN_W-1:0];
                    prev_reg  <= head_reg[lv_reg][GRAN_W-1:0];
                    buddy_reg <= head_reg[lv_reg][GRAN_W-1:0] ^ span_of(lv_reg);
                    if (lv_reg == '0 || head_reg[lv_reg][GRAN_W]) begin
                        state_reg <= ST_RESP;
                    end else begin
                        state_reg <= ST_MRG_CHK;
                    end
                end
                ST_MRG_CHK: begin
                    if (prev_reg == cur_reg) begin
                        cur_next_reg <= link_rdata;
                    end
                    if (link_rdata[GRAN_W]) begin
                        state_reg <= ST_RESP;
                    end else if (nx == buddy_reg) begin
                        state_reg <= ST_MRG_CUT;
                    end else begin
                        prev_reg <= nx;
                    end
                end
                ST_MRG_CUT: begin
                    head_reg[lv_reg] <= (prev_reg == cur_reg) ? link_rdata : cur_next_reg;
                    state_reg        <= ST_MRG_PSH;
                end
                ST_MRG_PSH: begin
                    head_reg[lv_reg - lvl_t'(1)] <= {1'b0, low_half};
                    lv_reg    <= lv_reg - lvl_t'(1);
                    state_reg <= ST_MRG;
                end
                ST_RESP: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign idle              = state_reg == ST_IDLE;
    assign res_valid         = (state_reg == ST_RESP) && res_ready;
    assign result.status     = status_reg;
    assign result.granted    = granted_reg;
    assign result.free_bytes = free_total_reg;

    a_free_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        free_total_reg <= REGION)
        else $error("free byte count exceeds the region size");

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (idle && start) |=> (state_reg == ST_DECODE))
        else $error("accepted word did not start decoding");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_RD) |-> !head_reg[lv_reg][GRAN_W])
        else $error("pop from an empty free list");

    a_split_below_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPL_RD) |-> (i_reg < lv_reg))
        else $error("split level not above the target level");
endmodule

@@ dv/buddy_block_allocator_check.sv @@
// Checker that predicts and compares every result word of the buddy block allocator.
`timescale 1ns / 100ps

module buddy_block_allocator_check
    import bba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          failures,
    output int          pending
);

    logic [31:0]       base_addr;
    logic [3:0]        hdr_bytes;
    int unsigned       head_of[NLEV];
    int unsigned       link_of[NGRAN];
    int unsigned       lvl_of[NGRAN];
    bit                taken[NGRAN];
    logic [CNT_W-1:0]  bytes_free;
    result_t           awaited[$];

    function automatic int unsigned gran_span(int unsigned lv);
        return 1 << (NLEV - 1 - lv);
    endfunction

    function automatic int unsigned take_head(int unsigned lv);
        int unsigned g;
        g = head_of[lv];
        if (g < NGRAN) head_of[lv] = link_of[g];
        return g;
    endfunction

    function automatic void put_head(int unsigned lv, int unsigned g);
        link_of[g] = head_of[lv];
        head_of[lv] = g;
    endfunction

    function automatic void coalesce(int unsigned lv);
        int unsigned cur, bud, prev, nx;
        bit found;
        while (lv > 0) begin
            cur = head_of[lv];
            found = 0;
            if (cur >= NGRAN) return;
            bud = cur ^ gran_span(lv);
            prev = cur;
            for (int n = 0; n < NGRAN && prev < NGRAN; n++) begin
                nx = link_of[prev];
                if (nx >= NGRAN) break;
                if (nx == bud) begin
                    link_of[prev] = link_of[nx];
                    head_of[lv] = link_of[cur];
                    put_head(lv - 1, cur < bud ? cur : bud);
                    found = 1;
                    break;
                end
                prev = nx;
            end
            if (!found) return;
            lv--;
        end
    endfunction

    function automatic result_t predict_word(logic cmd, logic [16:0] req, logic [31:0] fa);
        result_t r;
        logic [17:0] need;
        int unsigned lg, lv, i, big, upper, g;
        logic [31:0] off;
        bit have;
        r.status = STATUS_OK;
        r.granted = '0;
        if (cmd == CMD_ALLOC) begin
            need = 18'(req) + 18'(hdr_bytes);
            lg = 0;
            while ((18'd1 << lg) < need && lg < 18) lg++;
            if (lg > TOTAL_LOG) begin
                r.status = STATUS_TOO_BIG;
            end else begin
                lv = (lg < MIN_LOG) ? NLEV - 1 : TOTAL_LOG - lg;
                if (head_of[lv] >= NGRAN) begin
                    i = lv;
                    have = 0;
                    while (i > 0) begin
                        i--;
                        if (head_of[i] < NGRAN) begin
                            have = 1;
                            break;
                        end
                    end
                    if (!have) begin
                        r.status = STATUS_EXHAUSTED;
                    end else begin
                        while (i < lv) begin
                            big = take_head(i);
                            upper = big + gran_span(i + 1);
                            link_of[upper] = head_of[i + 1];
                            link_of[big] = upper;
                            head_of[i + 1] = big;
                            i++;
                        end
                    end
                end
                if (r.status == STATUS_OK) begin
                    g = take_head(lv);
                    lvl_of[g] = lv;
                    taken[g] = 1;
                    bytes_free -= CNT_W'(gran_span(lv) << MIN_LOG);
                    r.granted = base_addr + 32'(g << MIN_LOG) + 32'(hdr_bytes);
                end
            end
        end else if (fa != 0) begin
            off = fa - base_addr - 32'(hdr_bytes);
            if (off < (32'd1 << TOTAL_LOG) && off[MIN_LOG-1:0] == 0) begin
                g = off >> MIN_LOG;
                if (taken[g]) begin
                    lv = lvl_of[g];
                    taken[g] = 0;
                    put_head(lv, g);
                    bytes_free += CNT_W'(gran_span(lv) << MIN_LOG);
                    coalesce(lv);
                end
            end
        end
        r.free_bytes = bytes_free;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        int errs;
        if (!aresetn) begin
            base_addr <= '0;
            hdr_bytes <= 4'd8;
            for (int k = 0; k < NLEV; k++) head_of[k] = NGRAN;
            head_of[0] = 0;
            link_of[0] = NGRAN;
            for (int k = 0; k < NGRAN; k++) taken[k] = 0;
            bytes_free = REGION;
            awaited.delete();
            failures <= 0;
            pending <= 0;
        end else begin
            errs = 0;
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_BASE) base_addr <= cfg_wr_data;
                else hdr_bytes <= cfg_wr_data[3:0];
            end
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    $error("result word with nothing expected");
                    errs++;
                end else begin
                    want = awaited.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        errs++;
                    end
                    if (m_tdata[31:0] !== want.granted) begin
                        $error("granted_address: expected %h, got %h",
                               want.granted, m_tdata[31:0]);
                        errs++;
                    end
                    if (m_tdata[48:32] !== want.free_bytes) begin
                        $error("free_bytes: expected %0d, got %0d",
                               want.free_bytes, m_tdata[48:32]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited.push_back(predict_word(s_tuser, s_tdata[16:0], s_tdata[48:17]));
            failures <= failures + errs;
            pending <= awaited.size();
        end
    end

endmodule

@@ dv/buddy_block_allocator_test.sv @@
// Top of the buddy block allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module buddy_block_allocator_test;
    import bba_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic        cfg_addr = CFG_BASE;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = CMD_ALLOC;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    int          failures;
    int          pending;
    int unsigned cycles = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          burst_left = 0;
    logic [31:0] live_blocks[$];
    logic [31:0] freed_blocks[$];

    always #5 aclk = ~aclk;

    buddy_block_allocator uut (.*);

    buddy_block_allocator_check checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3_000_000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver stalls at random and once holds off for a long stretch.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end else if (!hold_done && s_tvalid && cycles > 8000) begin
            hold_done <= 1;
            hold_left <= 400;
            m_tready <= 0;
        end else if ((cycles / 512) % 3 == 0) begin
            m_tready <= 1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready && m_tuser == STATUS_OK && m_tdata[31:0] != 0)
            live_blocks.push_back(m_tdata[31:0]);
    end

    task automatic send_word(logic cmd, logic [16:0] req, logic [31:0] fa);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {7'b0, fa, req};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic settle;
        s_tvalid <= 0;
        burst_left = 0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (200) @(posedge aclk);
        live_blocks.delete();
        freed_blocks.delete();
    endtask

    task automatic release_all;
        logic [31:0] a;
        s_tvalid <= 0;
        burst_left = 0;
        @(posedge aclk);
        wait (pending == 0);
        while (live_blocks.size() > 0) begin
            a = live_blocks.pop_front();
            send_word(CMD_FREE, '0, a);
        end
    endtask

    task automatic random_words(int count);
        int k;
        logic [31:0] a;
        logic [16:0] req;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 55) begin
                k = $urandom_range(0, 99);
                if (k < 70) req = $urandom_range(0, 200);
                else if (k < 92) req = $urandom_range(0, 4000);
                else if (k < 97) req = $urandom_range(0, 40000);
                else req = $urandom_range(60000, 65536);
                send_word(CMD_ALLOC, req, $urandom);
            end else begin
                k = $urandom_range(0, 99);
                if (k < 80 && live_blocks.size() > 0) begin
                    k = $urandom_range(0, live_blocks.size() - 1);
                    a = live_blocks[k];
                    live_blocks.delete(k);
                    freed_blocks.push_back(a);
                end else if (k < 90 && freed_blocks.size() > 0) begin
                    a = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
                end else begin
                    a = $urandom;
                end
                send_word(CMD_FREE, $urandom, a);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // Directed: tiny, too big, whole region, exhaustion, null and invalid frees.
        send_word(CMD_ALLOC, 17'd0, '0);
        send_word(CMD_ALLOC, 17'd65536, '0);
        send_word(CMD_ALLOC, 17'h1FFFF, '0);
        send_word(CMD_FREE, '0, 32'd0);
        send_word(CMD_FREE, '0, 32'd8 + 32'd4);
        send_word(CMD_FREE, '0, 32'h0001_0008);
        send_word(CMD_FREE, '0, 32'd8 + 32'd16);
        send_word(CMD_FREE, '0, 32'd8);
        send_word(CMD_FREE, '0, 32'd8);
        send_word(CMD_ALLOC, 17'd65528, '0);
        send_word(CMD_ALLOC, 17'd1, '0);
        send_word(CMD_FREE, '0, 32'd8);
        for (int n = 0; n < 6; n++) send_word(CMD_ALLOC, 17'd1, '0);
        release_all();
        settle();

        write_reg(CFG_BASE, 32'hFFFF_FFF0);
        write_reg(CFG_HEADER, 32'd15);
        send_word(CMD_ALLOC, 17'd65521, '0);
        send_word(CMD_ALLOC, 17'd65522, '0);
        release_all();
        random_words(500);
        settle();

        write_reg(CFG_BASE, 32'd0);
        write_reg(CFG_HEADER, 32'd0);
        send_word(CMD_ALLOC, 17'd65536, '0);
        release_all();
        random_words(600);
        settle();

        write_reg(CFG_BASE, $urandom);
        write_reg(CFG_HEADER, $urandom_range(0, 15));
        random_words(600);

        s_tvalid <= 0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ buddy_block_allocator.f @@
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_engine.sv
hw/rtl/buddy_block_allocator.sv
dv/buddy_block_allocator_check.sv
dv/buddy_block_allocator_test.sv
